>>> rtl/core/esu_pkg.sv
// ----------------------------------------------------------------------------
// esu_pkg: shared types and constants for the string unescape unit
// Result codes, the record passed from classifier to emitter, hex decode.
// ----------------------------------------------------------------------------
package esu_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharN = 8'h6E;
  localparam logic [7:0] CharT = 8'h74;
  localparam logic [7:0] CharR = 8'h72;
  localparam logic [7:0] CharU = 8'h75;
  localparam logic [7:0] ByteLf = 8'h0A;
  localparam logic [7:0] ByteTab = 8'h09;
  localparam logic [7:0] ByteCr = 8'h0D;

  localparam logic [7:0] Utf8Lead2 = 8'b1100_0000;
  localparam logic [7:0] Utf8Lead3 = 8'b1110_0000;
  localparam logic [7:0] Utf8Cont = 8'b1000_0000;
  localparam logic [15:0] Utf8Max1 = 16'h007F;
  localparam logic [15:0] Utf8Max2 = 16'h07FF;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_OPEN   = 3'd1,
    ERR_END_STR   = 3'd2,
    ERR_END_ESC   = 3'd3,
    ERR_BAD_ESC   = 3'd4,
    ERR_BAD_HEX   = 3'd5
  } err_t;

  // One classified input byte: up to three results, drained in order.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    kind_t           kind;
    err_t            code;
  } op_t;

  // {invalid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/escaped_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// escaped_string_unescape_utf8_unit: quoted string unescaper with UTF-8 output
// One raw byte in, zero to three result items out, queue handshake on both
// sides.
// ----------------------------------------------------------------------------
// The unit takes one input byte every cycle while full is low; the classifier
// decides each byte in the cycle it is taken. Results leave one per cycle
// through the emitter while the consumer pops, so a \u escape that encodes
// to two or three UTF-8 bytes occupies the result side for one pop per byte.
// A queue of QUEUE_DEPTH records plus one head record sits between the two
// sides; full rises only when that queue fills because the consumer or a run
// of multibyte escapes has fallen behind. Records are registered into the
// head record. Bytes that cause no result (opening quote, backslash, u, hex
// digits before the last, the last digit of \u0000) never enter the queue.
module escaped_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = esu_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [2:0] error_code,
  output logic       last
);
  import esu_pkg::*;

  op_t  op;
  op_t  head;
  logic enq;
  logic deq;
  logic head_valid;

  esu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_full  (full),
    .in_byte (in_byte),
    .enq     (enq),
    .op      (op)
  );

  esu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .enq        (enq),
    .wdata      (op),
    .full       (full),
    .deq        (deq),
    .head_valid (head_valid),
    .head       (head)
  );

  esu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

>>> rtl/core/esu_front.sv
// ----------------------------------------------------------------------------
// esu_front: input byte classifier
// Runs the quote/escape/hex parser and turns each accepted byte into a record
// of zero to three results for the queue.
// ----------------------------------------------------------------------------
module esu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          q_full,
  input  logic [7:0]    in_byte,
  output logic          enq,
  output esu_pkg::op_t  op
);
  import esu_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_STR,
    PH_ESC,
    PH_HEX1,
    PH_HEX2,
    PH_HEX3,
    PH_HEX4
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] acc;
  logic [15:0] acc_next;
  logic [4:0]  hex;
  logic        accept;

  assign accept = push && !q_full;
  assign hex = hex_decode(in_byte);

  always_comb begin
    phase_next = phase;
    acc_next = acc;
    op.cnt = 2'd0;
    op.bytes = '0;
    op.kind = KIND_DATA;
    op.code = ERR_NONE;
    case (phase)
      PH_WAIT: begin
        if (in_byte == CharQuote) begin
          phase_next = PH_STR;
        end else begin
          op.cnt = 2'd1;
          op.kind = KIND_ERR;
          op.code = ERR_NO_OPEN;
        end
      end
      PH_STR: begin
        if (in_byte == CharQuote) begin
          op.cnt = 2'd1;
          op.kind = KIND_DONE;
          phase_next = PH_WAIT;
        end else if (in_byte == CharNul) begin
          op.cnt = 2'd1;
          op.kind = KIND_ERR;
          op.code = ERR_END_STR;
          phase_next = PH_WAIT;
        end else if (in_byte == CharBslash) begin
          phase_next = PH_ESC;
        end else begin
          op.cnt = 2'd1;
          op.bytes[0] = in_byte;
        end
      end
      PH_ESC: begin
        phase_next = PH_STR;
        op.cnt = 2'd1;
        if (in_byte == CharNul) begin
          op.kind = KIND_ERR;
          op.code = ERR_END_ESC;
          phase_next = PH_WAIT;
        end else if (in_byte == CharN) begin
          op.bytes[0] = ByteLf;
        end else if (in_byte == CharT) begin
          op.bytes[0] = ByteTab;
        end else if (in_byte == CharR) begin
          op.bytes[0] = ByteCr;
        end else if (in_byte == CharBslash || in_byte == CharQuote) begin
          op.bytes[0] = in_byte;
        end else if (in_byte == CharU) begin
          op.cnt = 2'd0;
          acc_next = '0;
          phase_next = PH_HEX1;
        end else begin
          op.kind = KIND_ERR;
          op.code = ERR_BAD_ESC;
          phase_next = PH_WAIT;
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        if (in_byte == CharNul) begin
          op.cnt = 2'd1;
          op.kind = KIND_ERR;
          op.code = ERR_END_STR;
          phase_next = PH_WAIT;
        end else if (hex[4]) begin
          op.cnt = 2'd1;
          op.kind = KIND_ERR;
          op.code = ERR_BAD_HEX;
          phase_next = PH_WAIT;
        end else begin
          acc_next = {acc[11:0], hex[3:0]};
          case (phase)
            PH_HEX1: phase_next = PH_HEX2;
            PH_HEX2: phase_next = PH_HEX3;
            PH_HEX3: phase_next = PH_HEX4;
            default: begin
              phase_next = PH_STR;
              // \u0000 yields nothing
              if (acc_next == '0) begin
                op.cnt = 2'd0;
              end else if (acc_next <= Utf8Max1) begin
                op.cnt = 2'd1;
                op.bytes[0] = acc_next[7:0];
              end else if (acc_next <= Utf8Max2) begin
                op.cnt = 2'd2;
                op.bytes[0] = Utf8Lead2 | {3'b000, acc_next[10:6]};
                op.bytes[1] = Utf8Cont | {2'b00, acc_next[5:0]};
              end else begin
                op.cnt = 2'd3;
                op.bytes[0] = Utf8Lead3 | {4'b0000, acc_next[15:12]};
                op.bytes[1] = Utf8Cont | {2'b00, acc_next[11:6]};
                op.bytes[2] = Utf8Cont | {2'b00, acc_next[5:0]};
              end
            end
          endcase
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  assign enq = accept && (op.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      acc <= '0;
    end else if (accept) begin
      phase <= phase_next;
      acc <= acc_next;
    end
  end

endmodule

>>> rtl/core/esu_queue.sv
// ----------------------------------------------------------------------------
// esu_queue: record queue between classifier and emitter
// Small memory plus a registered head entry; a write into an empty queue
// goes straight to the head.
// ----------------------------------------------------------------------------
module esu_queue #(
  parameter int DEPTH = esu_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  esu_pkg::op_t  wdata,
  output logic          full,
  input  logic          deq,
  output logic          head_valid,
  output esu_pkg::op_t  head
);
  import esu_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  op_t             mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] mcnt;
  logic            load;
  logic            from_mem;
  logic            bypass;
  logic            wr;

  assign full = (mcnt == CntW'(DEPTH));
  assign load = !head_valid || deq;
  assign from_mem = load && (mcnt != '0);
  assign bypass = load && (mcnt == '0) && enq;
  assign wr = enq && !bypass;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (from_mem) begin
      head <= mem[rd_ptr];
    end else if (bypass) begin
      head <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      mcnt <= '0;
    end else begin
      if (load) begin
        head_valid <= from_mem || bypass;
      end
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (from_mem) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      mcnt <= mcnt + CntW'(wr) - CntW'(from_mem);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    mcnt <= CntW'(DEPTH))
    else $error("queue count over depth");

  a_head_first: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> mcnt == '0)
    else $error("memory holds records while head is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq |-> !full)
    else $error("write into full queue");

endmodule

>>> rtl/core/esu_back.sv
// ----------------------------------------------------------------------------
// esu_back: result emitter
// Walks the head record one result per pop and retires it on its last one.
// ----------------------------------------------------------------------------
module esu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  esu_pkg::op_t  head,
  output logic          deq,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic [2:0]    error_code,
  output logic          last
);
  import esu_pkg::*;

  logic [1:0] idx;
  logic       take;

  assign empty = !head_valid;
  assign take = pop && head_valid;
  assign last = (idx == head.cnt - 2'd1);
  assign deq = take && last;
  assign out_byte = head.bytes[idx];
  assign kind = head.kind;
  assign error_code = head.code;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.cnt)
    else $error("result index past record");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.cnt != 2'd0)
    else $error("empty record reached emitter");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> idx == $past(idx) + 2'd1)
    else $error("result index did not advance");

endmodule
